// File: hdl/assert_macros.svh
// Assertion macros for the module that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/hrbe_pkg.sv
// Package with types, constants and helper functions of the HTTP body extractor.
package hrbe_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int LIT_LEN       = 26;
    localparam int POS_W         = 5;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_T     = 8'h54;

    typedef enum logic [2:0] {
        HP_LEAD    = 3'd0,
        HP_LINE    = 3'd1,
        HP_CR      = 3'd2,
        HP_LF      = 3'd3,
        HP_CRLF    = 3'd4,
        HP_CRLFCR  = 3'd5,
        HP_BODY    = 3'd6
    } header_phase_t;

    typedef enum logic [2:0] {
        CP_SIZE0    = 3'd0,
        CP_DIGITS   = 3'd1,
        CP_SKIPLINE = 3'd2,
        CP_DATA     = 3'd3,
        CP_TRAIL    = 3'd4
    } chunk_phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] body_byte;
        logic       end_of_body;
    } hrbe_result_t;

    // Characters of "Transfer-Encoding: chunked", indexed by match position.
    function automatic logic [7:0] lit_char(input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = "T";
            5'd1:    ch = "r";
            5'd2:    ch = "a";
            5'd3:    ch = "n";
            5'd4:    ch = "s";
            5'd5:    ch = "f";
            5'd6:    ch = "e";
            5'd7:    ch = "r";
            5'd8:    ch = "-";
            5'd9:    ch = "E";
            5'd10:   ch = "n";
            5'd11:   ch = "c";
            5'd12:   ch = "o";
            5'd13:   ch = "d";
            5'd14:   ch = "i";
            5'd15:   ch = "n";
            5'd16:   ch = "g";
            5'd17:   ch = ":";
            5'd18:   ch = " ";
            5'd19:   ch = "c";
            5'd20:   ch = "h";
            5'd21:   ch = "u";
            5'd22:   ch = "n";
            5'd23:   ch = "k";
            5'd24:   ch = "e";
            5'd25:   ch = "d";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/hrbe_parse.sv
// Header skipper, literal matcher and chunk decoder state for one byte per accepted cycle.
module hrbe_parse
    import hrbe_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         strip_header,
    input  logic         accept,
    input  logic [7:0]   data_byte,
    output hrbe_result_t result
);

    header_phase_t          header_phase_reg, header_phase_next;
    chunk_phase_t           chunk_phase_reg, chunk_phase_next;
    logic [POS_W-1:0]       match_pos_reg, match_pos_next;
    logic                   chunked_seen_reg, chunked_seen_next;
    logic                   finished_reg, finished_next;
    logic [SIZE_BITS-1:0]   remaining_reg, remaining_next;

    logic                   is_cr, is_lf, is_blank;
    logic                   hex_ok;
    logic [3:0]             hex_val;
    logic                   end_line;
    logic [SIZE_BITS-1:0]   rem_dec;

    assign is_cr    = (data_byte == CH_CR);
    assign is_lf    = (data_byte == CH_LF);
    assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
    assign rem_dec  = remaining_reg - {{(SIZE_BITS-1){1'b0}}, (remaining_reg != '0)};

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (data_byte >= "0" && data_byte <= "9")
        begin
            hex_val = 4'(data_byte - "0");
        end
        else if (data_byte >= "a" && data_byte <= "f")
        begin
            hex_val = 4'(data_byte - "a" + 8'd10);
        end
        else if (data_byte >= "A" && data_byte <= "F")
        begin
            hex_val = 4'(data_byte - "A" + 8'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_phase_reg <= HP_LEAD;
            chunk_phase_reg  <= CP_SIZE0;
            match_pos_reg    <= '0;
            chunked_seen_reg <= 1'b0;
            finished_reg     <= 1'b0;
            remaining_reg    <= '0;
        end
        else if (accept)
        begin
            header_phase_reg <= header_phase_next;
            chunk_phase_reg  <= chunk_phase_next;
            match_pos_reg    <= match_pos_next;
            chunked_seen_reg <= chunked_seen_next;
            finished_reg     <= finished_next;
            remaining_reg    <= remaining_next;
        end
    end

    always_comb
    begin
        header_phase_next = header_phase_reg;
        chunk_phase_next  = chunk_phase_reg;
        match_pos_next    = match_pos_reg;
        chunked_seen_next = chunked_seen_reg;
        finished_next     = finished_reg;
        remaining_next    = remaining_reg;
        end_line          = 1'b0;
        result            = '0;

        if (!strip_header)
        begin
            result.valid     = 1'b1;
            result.body_byte = data_byte;
        end
        else if (header_phase_reg != HP_BODY)
        begin
            // The letter T opens the literal and appears nowhere else in it.
            if (match_pos_reg < POS_W'(LIT_LEN) && data_byte == lit_char(match_pos_reg))
            begin
                if (match_pos_reg == POS_W'(LIT_LEN - 1))
                begin
                    chunked_seen_next = 1'b1;
                    match_pos_next    = '0;
                end
                else
                begin
                    match_pos_next = match_pos_reg + POS_W'(1);
                end
            end
            else
            begin
                match_pos_next = (data_byte == CH_T) ? POS_W'(1) : '0;
            end

            unique case (header_phase_reg)
                HP_LEAD:   if (!(is_cr || is_lf || is_blank)) header_phase_next = HP_LINE;
                HP_LINE:
                begin
                    if (is_cr)      header_phase_next = HP_CR;
                    else if (is_lf) header_phase_next = HP_LF;
                end
                HP_CR:     header_phase_next = is_lf ? HP_CRLF : HP_LINE;
                HP_LF:     header_phase_next = is_lf ? HP_BODY : HP_LINE;
                HP_CRLF:   header_phase_next = is_cr ? HP_CRLFCR : HP_LINE;
                HP_CRLFCR: header_phase_next = is_lf ? HP_BODY : HP_LINE;
                default:   header_phase_next = HP_LEAD;
            endcase
        end
        else if (!chunked_seen_reg)
        begin
            result.valid     = 1'b1;
            result.body_byte = data_byte;
        end
        else if (!finished_reg)
        begin
            unique case (chunk_phase_reg) inside
                CP_SIZE0, CP_DIGITS:
                begin
                    if (is_lf)
                    begin
                        end_line = 1'b1;
                    end
                    else if (hex_ok)
                    begin
                        // Saturate once another digit would overflow the size.
                        if (remaining_reg[SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            remaining_next = '1;
                        end
                        else
                        begin
                            remaining_next = {remaining_reg[SIZE_BITS-5:0], hex_val};
                        end
                        chunk_phase_next = CP_DIGITS;
                    end
                    else if (!(chunk_phase_reg == CP_SIZE0 && is_blank))
                    begin
                        chunk_phase_next = CP_SKIPLINE;
                    end
                end
                CP_SKIPLINE:
                begin
                    if (is_lf) end_line = 1'b1;
                end
                CP_DATA:
                begin
                    result.valid     = 1'b1;
                    result.body_byte = data_byte;
                    remaining_next   = rem_dec;
                    if (rem_dec == '0) chunk_phase_next = CP_TRAIL;
                end
                default:
                begin
                    if (is_lf) chunk_phase_next = CP_SIZE0;
                end
            endcase

            if (end_line)
            begin
                if (remaining_reg == '0)
                begin
                    finished_next      = 1'b1;
                    chunk_phase_next   = CP_SIZE0;
                    result.valid       = 1'b1;
                    result.end_of_body = 1'b1;
                end
                else
                begin
                    chunk_phase_next = CP_DATA;
                end
            end
        end
    end

endmodule

// File: hdl/http_response_body_extractor.sv
// A byte's result is registered in the output stage, or in the skid entry while the output stalls.
// Throughput: one byte per clock while in_stall is low; the parse logic is combinational and a
// two-entry output buffer lets input keep flowing while one result waits on a stall.
// The input stalls only while both output entries are full.
// Reset (rst_n low, asynchronous) clears all parse state, empties the output buffer and
// turns header stripping on.
`include "assert_macros.svh"

module http_response_body_extractor
    import hrbe_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] body_byte,
    output logic       end_of_body
);

    // The configuration register can be written at any time; the host must write it only
    // while no request is in flight, which the block itself does not enforce.
    logic         strip_reg;

    // Output stage plus one skid entry that catches a result when the
    // downstream side stalls.
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   out_byte_reg, out_byte_next;
    logic         out_eob_reg, out_eob_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [7:0]   skid_byte_reg, skid_byte_next;
    logic         skid_eob_reg, skid_eob_next;

    logic         in_accept;
    logic         out_free;
    hrbe_result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            strip_reg <= cfg_data;
        end
    end

    // A new request is taken whenever the skid entry is free, so the parser
    // never produces a result that has nowhere to go.
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    hrbe_parse #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .strip_header (strip_reg),
        .accept       (in_accept),
        .data_byte    (data_byte),
        .result       (result)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // When the output moves on, the skid entry (older) goes first; a fresh
    // result can only arrive while the skid entry is empty.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_eob_next    = out_eob_reg;
        skid_valid_next = skid_valid_reg;
        skid_byte_next  = skid_byte_reg;
        skid_eob_next   = skid_eob_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = skid_byte_reg;
                out_eob_next    = skid_eob_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_accept && result.valid;
                out_byte_next  = result.body_byte;
                out_eob_next   = result.end_of_body;
            end
        end
        else if (in_accept && result.valid)
        begin
            skid_valid_next = 1'b1;
            skid_byte_next  = result.body_byte;
            skid_eob_next   = result.end_of_body;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_eob_reg   <= out_eob_next;
        skid_byte_reg <= skid_byte_next;
        skid_eob_reg  <= skid_eob_next;
    end

    assign out_valid   = out_valid_reg;
    assign body_byte   = out_byte_reg;
    assign end_of_body = out_eob_reg;

    // The skid entry only fills behind a waiting output.
    `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // The end marker always carries a zero byte.
    `ASSERT_IMPL(a_end_zero_byte, clk, rst_n, out_valid_reg && out_eob_reg, out_byte_reg == 8'd0)
    // A full buffer with a stalled output stays full, so nothing is dropped.
    `ASSERT_NEXT(a_full_holds, clk, rst_n, skid_valid_reg && out_stall, skid_valid_reg)

endmodule

// File: test/hrbe_checker.sv
// Checker that predicts the body bytes of the HTTP body extractor and compares its output.
module hrbe_checker
    import hrbe_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] body_byte,
    input  logic       end_of_body,
    output int         mismatches,
    output int         pending,
    output int         results
);

    typedef struct packed {
        logic [7:0] body_byte;
        logic       end_of_body;
    } body_item_t;

    localparam logic [8*LIT_LEN-1:0] KEYWORD  = "Transfer-Encoding: chunked";
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

    body_item_t           body_due[$];
    logic                 strip_on;
    header_phase_t        hphase;
    logic [POS_W-1:0]     mpos;
    logic                 chunked;
    chunk_phase_t         cphase;
    logic [SIZE_BITS-1:0] remaining;
    logic                 finished;
    int                   err_count = 0;
    int                   got_count = 0;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    task automatic note_mismatch(input string what);
        err_count++;
        if (err_count <= 10)
            $display("mismatch: %s", what);
    endtask

    // Works out what one accepted request byte produces and queues it.
    task automatic predict_body(input logic [7:0] c);
        int   d;
        logic line_done;
        line_done = 1'b0;
        if (!strip_on)
        begin
            body_due.push_back(body_item_t'{c, 1'b0});
            return;
        end
        if (hphase != HP_BODY)
        begin
            if (mpos < LIT_LEN && c == KEYWORD[8*(LIT_LEN-1-int'(mpos)) +: 8])
            begin
                mpos = mpos + 1'b1;
                if (mpos == LIT_LEN)
                begin
                    chunked = 1'b1;
                    mpos    = '0;
                end
            end
            else
                mpos = (c == CH_T) ? 5'd1 : 5'd0;
            case (hphase)
                HP_LEAD:
                    if (c != CH_CR && c != CH_LF && c != CH_SPACE && c != CH_TAB)
                        hphase = HP_LINE;
                HP_LINE:
                    if (c == CH_CR)
                        hphase = HP_CR;
                    else if (c == CH_LF)
                        hphase = HP_LF;
                HP_CR:     hphase = (c == CH_LF) ? HP_CRLF : HP_LINE;
                HP_LF:     hphase = (c == CH_LF) ? HP_BODY : HP_LINE;
                HP_CRLF:   hphase = (c == CH_CR) ? HP_CRLFCR : HP_LINE;
                HP_CRLFCR: hphase = (c == CH_LF) ? HP_BODY : HP_LINE;
                default:   hphase = HP_LEAD;
            endcase
            return;
        end
        if (!chunked)
        begin
            body_due.push_back(body_item_t'{c, 1'b0});
            return;
        end
        if (finished)
            return;
        case (cphase)
            CP_SIZE0, CP_DIGITS:
            begin
                d = hex_digit(c);
                if (c == CH_LF)
                    line_done = 1'b1;
                else if (d >= 0)
                begin
                    if (remaining > (SIZE_MAX >> 4))
                        remaining = SIZE_MAX;
                    else
                        remaining = {remaining[SIZE_BITS-5:0], 4'(d)};
                    cphase = CP_DIGITS;
                end
                else if (!(cphase == CP_SIZE0 && (c == CH_SPACE || c == CH_TAB)))
                    cphase = CP_SKIPLINE;
            end
            CP_SKIPLINE:
                if (c == CH_LF)
                    line_done = 1'b1;
            CP_DATA:
            begin
                body_due.push_back(body_item_t'{c, 1'b0});
                if (remaining != 0)
                    remaining = remaining - 1'b1;
                if (remaining == 0)
                    cphase = CP_TRAIL;
            end
            default:
                if (c == CH_LF)
                    cphase = CP_SIZE0;
        endcase
        if (line_done)
        begin
            if (remaining == 0)
            begin
                finished = 1'b1;
                cphase   = CP_SIZE0;
                body_due.push_back(body_item_t'{8'h00, 1'b1});
            end
            else
                cphase = CP_DATA;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        body_item_t want;
        if (!rst_n)
        begin
            strip_on  = 1'b1;
            hphase    = HP_LEAD;
            mpos      = '0;
            chunked   = 1'b0;
            cphase    = CP_SIZE0;
            remaining = '0;
            finished  = 1'b0;
            body_due.delete();
            mismatches <= 0;
            pending    <= 0;
            results    <= 0;
        end
        else
        begin
            // A result can never come from a request taken at the same edge,
            // so the output side is settled first.
            if (out_valid && !out_stall)
            begin
                got_count++;
                if (body_due.size() == 0)
                    note_mismatch($sformatf("byte=%02h end=%0b arrived with nothing expected",
                                            body_byte, end_of_body));
                else
                begin
                    want = body_due.pop_front();
                    if (body_byte !== want.body_byte || end_of_body !== want.end_of_body)
                        note_mismatch($sformatf("expected byte=%02h end=%0b, got byte=%02h end=%0b",
                                                want.body_byte, want.end_of_body,
                                                body_byte, end_of_body));
                end
            end
            if (cfg_valid && cfg_ready)
                strip_on = cfg_data;
            if (in_valid && !in_stall)
                predict_body(data_byte);
            mismatches <= err_count;
            pending    <= body_due.size();
            results    <= got_count;
        end
    end

endmodule

// File: test/tb.sv
// Top of the HTTP body extractor testbench: clock, reset, request stimulus and verdict.
module tb;
    import hrbe_pkg::*;

    // Number of request bytes the run aims for, and the hard stop in time units.
    localparam int BYTE_TARGET = 1350;
    localparam int RUN_LIMIT   = 400000;

    // Since reset happens only once, a run sees one response. Its body either
    // passes unchanged, stays open in a saturated chunk, or is closed by a
    // zero-size chunk.
    typedef enum int { PLAIN_BODY, CHUNKED_OPEN, CHUNKED_CLOSED } ending_t;

    // Idle patterns, stepped through as the request count grows.
    typedef enum int { GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH } gap_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_data  = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       out_stall = 1'b0;
    wire        cfg_ready;
    wire        in_stall;
    wire        out_valid;
    wire  [7:0] body_byte;
    wire        end_of_body;

    int        mismatches;
    int        pending;
    int        results;
    int        sent       = 0;
    int        cfg_writes = 0;
    gap_mode_t gap_mode   = GAPS_NONE;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    http_response_body_extractor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .body_byte   (body_byte),
        .end_of_body (end_of_body)
    );

    hrbe_checker #(
        .SIZE_BITS (SIZE_BITS_DEF)
    ) watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .body_byte   (body_byte),
        .end_of_body (end_of_body),
        .mismatches  (mismatches),
        .pending     (pending),
        .results     (results)
    );

    // The receiver stalls at random according to the current idle pattern.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) <
                      ((gap_mode == GAPS_RECEIVER) ? 61 : (gap_mode == GAPS_BOTH) ? 30 : 0));
    end

    // Offers one request byte, with random idle cycles before it, and returns
    // at the edge where it was taken. Valid stays high when the next request
    // follows without a gap.
    task automatic send_byte(input logic [7:0] b);
        int idle_pct;
        idle_pct = (gap_mode == GAPS_SENDER) ? 61 : ((gap_mode == GAPS_BOTH) ? 30 : 0);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        gap_mode <= gap_mode_t'((sent / 150) % 4);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Random byte that can sit inside a line: never CR or LF, mostly printable.
    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        do
            b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
        while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte(input bit with_line_ends);
        case ($urandom_range(0, with_line_ends ? 3 : 1))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Stops offering requests until every expected result is out, then waits a
    // few more cycles, since header bytes and line ends are consumed silently.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The strip register is only written while the block is idle.
    task automatic write_strip(input logic v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Turns stripping off for a short burst of raw bytes, which must pass
    // unchanged, then turns it back on so decoding resumes where it stood.
    task automatic pass_through_burst();
        write_strip(1'b0);
        repeat ($urandom_range(2, 10)) send_byte(8'($urandom));
        write_strip(1'b1);
    endtask

    // Blank lead-in, a few header lines and the empty line that ends them.
    // Line ends are either all CR LF or all bare LF, since a mix would not
    // close the header the same way.
    task automatic send_header(input bit with_keyword);
        string key;
        string near;
        int    lines;
        int    key_at;
        int    pos;
        bit    lf_only;
        key     = "Transfer-Encoding: chunked";
        lf_only = $urandom_range(0, 1);
        repeat ($urandom_range(0, 4)) send_byte(blank_byte(1'b1));
        lines  = $urandom_range(2, 7);
        key_at = $urandom_range(0, lines - 1);
        for (int i = 0; i < lines; i++)
        begin
            if (with_keyword && i == key_at)
            begin
                case ($urandom_range(0, 2))
                    0: ;
                    // A doubled T forces the matcher to restart mid-word.
                    1: send_byte(CH_T);
                    // The keyword is also found in the middle of a line.
                    default: send_text("X-Via: ");
                endcase
                send_text(key);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                // Near misses: either one character is off or the line stops short.
                pos = $urandom_range(0, LIT_LEN - 2);
                if ($urandom_range(0, 1) == 0)
                begin
                    near      = key;
                    near[pos] = near[pos] ^ 8'h01;
                    send_text(near);
                end
                else
                    send_text(key.substr(0, pos));
            end
            else
            begin
                repeat ($urandom_range(1, 30)) send_byte(line_byte());
                // A lone CR inside a line must not count as a line end.
                if ($urandom_range(0, 5) == 0)
                begin
                    send_byte(CH_CR);
                    send_byte(line_byte());
                end
            end
            if (!lf_only)
                send_byte(CH_CR);
            send_byte(CH_LF);
        end
        if (!lf_only)
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // A chunk size line: optional blanks, hex digits in mixed case, an
    // optional extension that the block must skip, and CR LF or a bare LF.
    task automatic send_size_line(input string digits);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_byte(blank_byte(1'b0));
        for (int i = 0; i < digits.len(); i++)
        begin
            if (digits[i] >= "a" && digits[i] <= "f" && $urandom_range(0, 1) == 1)
                digits[i] = digits[i] - 8'h20;
        end
        send_text(digits);
        if ($urandom_range(0, 3) == 0)
        begin
            send_byte(";");
            repeat ($urandom_range(0, 6)) send_byte(line_byte());
        end
        if ($urandom_range(0, 3) != 0)
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_chunk(input int size);
        string digits;
        int    burst_at;
        digits = $sformatf("%0h", size);
        if ($urandom_range(0, 4) == 0)
            digits = {"00", digits};
        burst_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, size - 1) : -1;
        send_size_line(digits);
        for (int i = 0; i < size; i++)
        begin
            if (i == burst_at)
                pass_through_burst();
            send_byte(8'($urandom));
        end
        // Everything up to the next LF after the data is dropped.
        case ($urandom_range(0, 5))
            0: send_byte(CH_LF);
            1:
            begin
                repeat ($urandom_range(1, 3)) send_byte(line_byte());
                send_byte(CH_LF);
            end
            default:
            begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
        endcase
    endtask

    initial
    begin
        #(RUN_LIMIT);
        $display("http_response_body_extractor test failed");
        $finish;
    end

    initial
    begin
        ending_t ending;
        int      pick;
        int      size;
        ending = ($urandom_range(0, 5) == 0) ? PLAIN_BODY :
                 (($urandom_range(0, 3) == 0) ? CHUNKED_OPEN : CHUNKED_CLOSED);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed start: with stripping off, extreme and special bytes must
        // come straight through; then stripping goes back on for the header.
        write_strip(1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_T);
        send_byte(8'h80);
        send_byte(8'h7F);
        write_strip(1'b1);

        send_header(ending != PLAIN_BODY);

        if (ending == PLAIN_BODY)
        begin
            // Without the keyword every body byte passes.
            while (sent < BYTE_TARGET)
            begin
                if ($urandom_range(0, 39) == 0)
                    pass_through_burst();
                send_byte(8'($urandom));
            end
        end
        else
        begin
            // Mostly short chunks, a few medium ones and the odd long one.
            while (sent < BYTE_TARGET - 90)
            begin
                if ($urandom_range(0, 11) == 0)
                    pass_through_burst();
                pick = $urandom_range(0, 19);
                size = (pick < 14) ? $urandom_range(1, 16) :
                       ((pick < 19) ? $urandom_range(17, 64) : $urandom_range(200, 300));
                send_chunk(size);
            end
            if (ending == CHUNKED_OPEN)
            begin
                // A size too large for the counter saturates, so data keeps flowing.
                send_size_line(($urandom_range(0, 1) == 0) ? "ffffffffff" : "100000000");
                while (sent < BYTE_TARGET)
                begin
                    if ($urandom_range(0, 29) == 0)
                        pass_through_burst();
                    send_byte(8'($urandom));
                end
            end
            else
            begin
                // The last chunk: zero, padded zeros, or a size line with no digits.
                case ($urandom_range(0, 3))
                    0: send_size_line("0");
                    1: send_size_line("000");
                    2:
                    begin
                        send_byte(CH_SPACE);
                        send_byte(CH_LF);
                    end
                    default:
                    begin
                        send_byte(CH_CR);
                        send_byte(CH_LF);
                    end
                endcase
                // After the end marker bytes are dropped, unless stripping is off.
                while (sent < BYTE_TARGET)
                begin
                    if ($urandom_range(0, 19) == 0)
                        pass_through_burst();
                    send_byte(8'($urandom));
                end
            end
        end

        wait_idle();
        $display("covered %0d request bytes, %0d results and %0d strip writes, ending %s",
                 sent, results, cfg_writes, ending.name());
        $display("idle patterns stepped through none, sender gaps, receiver stalls and both");
        if (mismatches == 0 && pending == 0)
            $display("http_response_body_extractor test passed");
        else
            $display("http_response_body_extractor test failed");
        $finish;
    end

endmodule
